// ===== sv/assert_macros.svh =====
// Shared assertion macros for the list engine checkers.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge outside reset.
`define OALE_ASSERT(lbl, ck, rstn, prop, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) prop) else $error(msg);

// Check on every clock edge, reset included.
`define OALE_ASSERT_ALWAYS(lbl, ck, prop, msg) \
	lbl: assert property (@(posedge ck) prop) else $error(msg);

`endif

// ===== sv/oale_pkg.sv =====
`timescale 1ns / 1ps

package oale_pkg;

	localparam int DEPTH = 64;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = $clog2(DEPTH + 1);
	localparam int VW    = 32;

	typedef enum logic [2:0] {
		OP_APPEND  = 3'd0,
		OP_INSERT  = 3'd1,
		OP_DEL_VAL = 3'd2,
		OP_DEL_AT  = 3'd3,
		OP_READ    = 3'd4,
		OP_FIND    = 3'd5
	} op_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_FULL     = 2'd1,
		ST_RANGE    = 2'd2,
		ST_NOTFOUND = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		WALK_NONE   = 2'd0,
		WALK_SEARCH = 2'd1,
		WALK_UP     = 2'd2,
		WALK_DOWN   = 2'd3
	} walk_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DISPATCH,
		S_SEARCH,
		S_REMOVE,
		S_SHIFT_DN,
		S_SHIFT_UP,
		S_READ_WAIT,
		S_DONE
	} state_t;

	typedef struct packed {
		logic    load_item;
		walk_t   walk;
		walk_t   init_walk;
		logic    append;
		logic    put;
		logic    dec;
		logic    take_hit;
		logic    set_found;
		logic    set_status;
		status_t status;
		logic    read_issue;
		logic    read_capture;
		logic    load_out;
	} ctrl_cmd_t;

	typedef struct packed {
		op_t  op;
		logic full;
		logic pos_bad;
		logic hit;
		logic walk_idle;
		logic out_free;
	} dp_stat_t;

	function automatic logic [CW-1:0] eff_cap(input logic [CW-1:0] cap);
		if (cap > CW'(DEPTH)) begin
			return CW'(DEPTH);
		end
		return cap;
	endfunction

endpackage

// ===== sv/oale_ctrl.sv =====
`timescale 1ns / 1ps

module oale_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  oale_pkg::dp_stat_t   stat,
	output oale_pkg::ctrl_cmd_t  cmd
);

	oale_pkg::state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= oale_pkg::S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			oale_pkg::S_IDLE: begin
				if (s_tvalid) state_nx = oale_pkg::S_DISPATCH;
			end
			oale_pkg::S_DISPATCH: begin
				case (stat.op)
					oale_pkg::OP_INSERT: begin
						if (stat.pos_bad || stat.full) state_nx = oale_pkg::S_DONE;
						else state_nx = oale_pkg::S_SHIFT_UP;
					end
					oale_pkg::OP_DEL_VAL, oale_pkg::OP_FIND: begin
						state_nx = oale_pkg::S_SEARCH;
					end
					oale_pkg::OP_DEL_AT: begin
						if (stat.pos_bad) state_nx = oale_pkg::S_DONE;
						else state_nx = oale_pkg::S_REMOVE;
					end
					oale_pkg::OP_READ: begin
						if (stat.pos_bad) state_nx = oale_pkg::S_DONE;
						else state_nx = oale_pkg::S_READ_WAIT;
					end
					default: state_nx = oale_pkg::S_DONE;
				endcase
			end
			oale_pkg::S_SEARCH: begin
				if (stat.hit) begin
					if (stat.op == oale_pkg::OP_FIND) state_nx = oale_pkg::S_DONE;
					else state_nx = oale_pkg::S_REMOVE;
				end else if (stat.walk_idle) begin
					state_nx = oale_pkg::S_DONE;
				end
			end
			oale_pkg::S_REMOVE:    state_nx = oale_pkg::S_SHIFT_DN;
			oale_pkg::S_SHIFT_DN: begin
				if (stat.walk_idle) state_nx = oale_pkg::S_DONE;
			end
			oale_pkg::S_SHIFT_UP: begin
				if (stat.walk_idle) state_nx = oale_pkg::S_DONE;
			end
			oale_pkg::S_READ_WAIT: state_nx = oale_pkg::S_DONE;
			oale_pkg::S_DONE: begin
				if (stat.out_free) state_nx = oale_pkg::S_IDLE;
			end
			default: state_nx = oale_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd        = '0;
		cmd.walk   = oale_pkg::WALK_NONE;
		cmd.status = oale_pkg::ST_OK;
		s_tready   = 1'b0;
		case (state_q)
			oale_pkg::S_IDLE: begin
				s_tready      = 1'b1;
				cmd.load_item = s_tvalid;
			end
			oale_pkg::S_DISPATCH: begin
				case (stat.op)
					oale_pkg::OP_APPEND: begin
						if (stat.full) begin
							cmd.set_status = 1'b1;
							cmd.status     = oale_pkg::ST_FULL;
						end else begin
							cmd.append = 1'b1;
						end
					end
					oale_pkg::OP_INSERT: begin
						if (stat.pos_bad) begin
							cmd.set_status = 1'b1;
							cmd.status     = oale_pkg::ST_RANGE;
						end else if (stat.full) begin
							cmd.set_status = 1'b1;
							cmd.status     = oale_pkg::ST_FULL;
						end else begin
							cmd.init_walk = oale_pkg::WALK_UP;
						end
					end
					oale_pkg::OP_DEL_VAL, oale_pkg::OP_FIND: begin
						cmd.init_walk = oale_pkg::WALK_SEARCH;
					end
					oale_pkg::OP_DEL_AT: begin
						if (stat.pos_bad) begin
							cmd.set_status = 1'b1;
							cmd.status     = oale_pkg::ST_RANGE;
						end
					end
					oale_pkg::OP_READ: begin
						if (stat.pos_bad) begin
							cmd.set_status = 1'b1;
							cmd.status     = oale_pkg::ST_RANGE;
						end else begin
							cmd.read_issue = 1'b1;
						end
					end
					default: ;
				endcase
			end
			oale_pkg::S_SEARCH: begin
				cmd.walk = oale_pkg::WALK_SEARCH;
				if (stat.hit) begin
					if (stat.op == oale_pkg::OP_FIND) cmd.set_found = 1'b1;
					else cmd.take_hit = 1'b1;
				end else if (stat.walk_idle) begin
					cmd.set_status = 1'b1;
					cmd.status     = oale_pkg::ST_NOTFOUND;
				end
			end
			oale_pkg::S_REMOVE: begin
				cmd.init_walk = oale_pkg::WALK_DOWN;
			end
			oale_pkg::S_SHIFT_DN: begin
				cmd.walk = oale_pkg::WALK_DOWN;
				cmd.dec  = stat.walk_idle;
			end
			oale_pkg::S_SHIFT_UP: begin
				cmd.walk = oale_pkg::WALK_UP;
				// drop the new value into the opened slot once the shift drains
				cmd.put  = stat.walk_idle;
			end
			oale_pkg::S_READ_WAIT: begin
				cmd.read_capture = 1'b1;
			end
			oale_pkg::S_DONE: begin
				cmd.load_out = stat.out_free;
			end
			default: ;
		endcase
	end

endmodule

// ===== sv/oale_dp.sv =====
`timescale 1ns / 1ps

module oale_dp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [47:0]          s_tdata,
	input  logic                 cfg_wen,
	input  logic [6:0]           cfg_wdata,
	input  oale_pkg::ctrl_cmd_t  cmd,
	output oale_pkg::dp_stat_t   stat,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [47:0]          m_tdata
);

	localparam int AW = oale_pkg::AW;
	localparam int CW = oale_pkg::CW;
	localparam int VW = oale_pkg::VW;

	logic [VW-1:0]          mem [oale_pkg::DEPTH];

	logic [2:0]             op_q;
	logic [AW-1:0]          pos_q;
	logic [VW-1:0]          val_q;
	logic [CW-1:0]          count_q;
	logic [CW-1:0]          cap_q;
	logic [CW-1:0]          idx_q;
	logic                   rv_s1;
	logic [AW-1:0]          tag_s1;
	logic [VW-1:0]          rd_s1;
	oale_pkg::status_t      res_status_q;
	logic [AW-1:0]          res_found_q;
	logic [VW-1:0]          res_value_q;
	logic                   out_valid_q;
	logic [47:0]            out_data_q;

	logic [CW-1:0]          eff;
	logic [CW-1:0]          pos_ext;
	logic [CW-1:0]          idx_m1;
	logic                   issue;
	logic [AW-1:0]          ra;
	logic                   we;
	logic [AW-1:0]          wa;
	logic [VW-1:0]          wd;

	assign eff     = oale_pkg::eff_cap(cap_q);
	assign pos_ext = {1'b0, pos_q};
	assign idx_m1  = idx_q - CW'(1);

	always_comb begin
		case (cmd.walk)
			oale_pkg::WALK_SEARCH, oale_pkg::WALK_DOWN: issue = idx_q < count_q;
			oale_pkg::WALK_UP:                          issue = idx_q > pos_ext;
			default:                                    issue = 1'b0;
		endcase
	end

	always_comb begin
		case (cmd.walk)
			oale_pkg::WALK_SEARCH, oale_pkg::WALK_DOWN: ra = idx_q[AW-1:0];
			oale_pkg::WALK_UP:                          ra = idx_m1[AW-1:0];
			default:                                    ra = pos_q;
		endcase
	end

	always_comb begin
		we = 1'b0;
		wa = pos_q;
		wd = val_q;
		if ((cmd.walk == oale_pkg::WALK_UP || cmd.walk == oale_pkg::WALK_DOWN) && rv_s1) begin
			we = 1'b1;
			wa = tag_s1;
			wd = rd_s1;
		end else if (cmd.append) begin
			we = 1'b1;
			wa = count_q[AW-1:0];
		end else if (cmd.put) begin
			we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (we) mem[wa] <= wd;
		rd_s1 <= mem[ra];
	end

	assign stat.op        = oale_pkg::op_t'(op_q);
	assign stat.full      = count_q >= eff;
	assign stat.pos_bad   = (pos_ext >= count_q) || (pos_ext >= eff);
	assign stat.hit       = (cmd.walk == oale_pkg::WALK_SEARCH) && rv_s1 && (rd_s1 == val_q);
	assign stat.walk_idle = !issue && !rv_s1;
	assign stat.out_free  = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			cap_q       <= CW'(oale_pkg::DEPTH);
			rv_s1       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wen) cap_q <= cfg_wdata;
			if (cmd.append || cmd.put) count_q <= count_q + CW'(1);
			else if (cmd.dec) count_q <= count_q - CW'(1);
			rv_s1 <= issue;
			if (cmd.load_out) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			op_q         <= s_tdata[2:0];
			pos_q        <= s_tdata[8:3];
			val_q        <= s_tdata[40:9];
			res_status_q <= oale_pkg::ST_OK;
			res_found_q  <= '0;
			res_value_q  <= '0;
		end
		case (cmd.init_walk)
			oale_pkg::WALK_SEARCH: idx_q <= '0;
			oale_pkg::WALK_UP:     idx_q <= count_q;
			oale_pkg::WALK_DOWN:   idx_q <= pos_ext + CW'(1);
			default: begin
				if (issue) begin
					if (cmd.walk == oale_pkg::WALK_UP) idx_q <= idx_m1;
					else idx_q <= idx_q + CW'(1);
				end
			end
		endcase
		// tag the read in flight with its write slot, or its position on a search
		tag_s1 <= (cmd.walk == oale_pkg::WALK_DOWN) ? idx_m1[AW-1:0] : idx_q[AW-1:0];
		if (cmd.take_hit) pos_q <= tag_s1;
		if (cmd.set_found) res_found_q <= tag_s1;
		if (cmd.read_capture) res_value_q <= rd_s1;
		if (cmd.set_status) res_status_q <= cmd.status;
		if (cmd.load_out) begin
			out_data_q <= {1'b0, count_q, res_value_q, res_found_q, res_status_q};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

// ===== sv/ordered_array_list_engine.sv =====
`timescale 1ns / 1ps
// Ordered list engine: a bounded list of 32-bit values in a 64-entry memory.
// Commands arrive on the s_ stream, one result per command leaves on m_.
// Command codes: append, insert at position, delete by value, delete at
// position, read, find. Codes six and seven do nothing and report ok.
// cfg_wen/cfg_wdata set the capacity (above 64 counts as 64); write it only
// while no command is in flight.
// One command is worked at a time, in these steps after dispatch:
//   append, rejected commands and unused codes: straight to the result;
//   read: a memory read, then the result;
//   find: a scan from position zero up to the first hit or the end;
//   insert: the entries from position on shift up, then the value is written;
//   delete at position: the entries after position shift down;
//   delete by value: the scan, then the shift down from the hit.
// The walks are paced by the entry memory: one read and one write per cycle.
// s_tready is high only while idle; a finished result sits in the output
// register, so the next command is taken while m_ is stalled, and its result
// waits until the previous one is taken.
// arst_n empties the list, sets capacity to 64 and drops m_tvalid; memory
// contents are not cleared.
module ordered_array_list_engine (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,  // command[2:0], position[8:3], item_value[40:9], zero pad
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,  // status[1:0], found_position[7:2], read_value[39:8],
	                              // entry_count[46:40], zero pad
	input  logic        cfg_wen,
	input  logic [6:0]  cfg_wdata
);

	oale_pkg::ctrl_cmd_t cmd;
	oale_pkg::dp_stat_t  stat;

	oale_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	oale_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tdata   (s_tdata),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.stat      (stat),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule

// ===== sv/oale_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module oale_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [47:0] m_tdata
);

	// hold a stalled result
	`OALE_ASSERT(a_out_hold, clk, arst_n, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "stalled result changed")

	// a found position or read value only comes with an ok status
	`OALE_ASSERT(a_status_ok, clk, arst_n, m_tvalid && (m_tdata[7:2] != 6'd0 || m_tdata[39:8] != 32'd0) |-> m_tdata[1:0] == 2'd0, "payload with error status")

	// one command at a time: a result never follows its accept in the next cycle
	`OALE_ASSERT(a_busy, clk, arst_n, s_tvalid && s_tready |=> !s_tready && !$rose(m_tvalid), "accept not followed by busy")

	`OALE_ASSERT_ALWAYS(a_rst, clk, !arst_n |-> !m_tvalid, "result valid during reset")

endmodule

bind ordered_array_list_engine oale_checker u_oale_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// ===== dv/tb_ordered_array_list_engine.sv =====
`timescale 1ns / 1ps

module tb_ordered_array_list_engine;

	localparam int          CYCLE_LIMIT = 1_000_000;
	localparam int          WORST_WALK  = 2 * oale_pkg::DEPTH + 20;
	localparam logic [2:0]  CMD_SPARE_6 = 3'd6;
	localparam logic [2:0]  CMD_SPARE_7 = 3'd7;

	typedef struct {
		oale_pkg::status_t status;
		logic [5:0]        found_position;
		logic [31:0]       read_value;
		logic [6:0]        entry_count;
	} list_result_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [47:0] s_tdata;   // command[2:0], position[8:3], item_value[40:9], zero pad
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;   // status[1:0], found_position[7:2], read_value[39:8],
	                        // entry_count[46:40], zero pad
	logic        cfg_wen;
	logic [6:0]  cfg_wdata;

	// shadow copy of the list as the block should hold it
	logic [31:0]  shadow_entries [oale_pkg::DEPTH];
	logic [6:0]   shadow_len;
	logic [6:0]   shadow_cap;

	list_result_t list_results_due[$];
	list_result_t oldest_due;
	int           mismatches;
	int           items_sent;
	int           results_checked;
	int           cap_writes;
	int           cycle_count = 0;
	int           stall_left = 0;
	bit           quiet;

	ordered_array_list_engine DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_wen  (cfg_wen),
		.cfg_wdata(cfg_wdata)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
			         list_results_due.size());
			$display("ordered_array_list_engine test failed");
			$finish;
		end
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
	                               input logic [31:0] want);
		if (mismatches < 40) begin
			$display("%0t: %s: got %0h, want %0h", $time, what, got, want);
		end
		mismatches++;
	endtask

	function automatic void remove_entry(input int at);
		for (int i = at; i + 1 < shadow_len; i++) begin
			shadow_entries[i] = shadow_entries[i + 1];
		end
		shadow_len--;
	endfunction

	function automatic list_result_t apply_list_cmd(input logic [2:0] cmd,
	                                                input logic [5:0] pos,
	                                                input logic [31:0] val);
		list_result_t r;
		int lim;
		int hit_at;
		bit pos_bad;
		r.status         = oale_pkg::ST_OK;
		r.found_position = '0;
		r.read_value     = '0;
		lim    = (shadow_cap > oale_pkg::DEPTH) ? oale_pkg::DEPTH : int'(shadow_cap);
		hit_at = -1;
		for (int i = 0; i < shadow_len; i++) begin
			if (hit_at < 0 && shadow_entries[i] == val) begin
				hit_at = i;
			end
		end
		pos_bad = (pos >= shadow_len) || (int'(pos) >= lim);
		case (cmd)
			oale_pkg::OP_APPEND: begin
				if (shadow_len >= lim) begin
					r.status = oale_pkg::ST_FULL;
				end else begin
					shadow_entries[shadow_len] = val;
					shadow_len++;
				end
			end
			oale_pkg::OP_INSERT: begin
				// position check wins over the full check
				if (pos_bad) begin
					r.status = oale_pkg::ST_RANGE;
				end else if (shadow_len >= lim) begin
					r.status = oale_pkg::ST_FULL;
				end else begin
					for (int i = shadow_len; i > pos; i--) begin
						shadow_entries[i] = shadow_entries[i - 1];
					end
					shadow_entries[pos] = val;
					shadow_len++;
				end
			end
			oale_pkg::OP_DEL_VAL: begin
				if (hit_at < 0) begin
					r.status = oale_pkg::ST_NOTFOUND;
				end else begin
					remove_entry(hit_at);
				end
			end
			oale_pkg::OP_DEL_AT: begin
				if (pos_bad) begin
					r.status = oale_pkg::ST_RANGE;
				end else begin
					remove_entry(pos);
				end
			end
			oale_pkg::OP_READ: begin
				if (pos_bad) begin
					r.status = oale_pkg::ST_RANGE;
				end else begin
					r.read_value = shadow_entries[pos];
				end
			end
			oale_pkg::OP_FIND: begin
				if (hit_at < 0) begin
					r.status = oale_pkg::ST_NOTFOUND;
				end else begin
					r.found_position = 6'(hit_at);
				end
			end
			default: begin
			end
		endcase
		r.entry_count = shadow_len;
		return r;
	endfunction

	function automatic int sender_gap();
		int r;
		if (quiet) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return 0;
		end else if (r < 90) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	// result checker and receiver stalls
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (list_results_due.size() == 0) begin
				report_mismatch("result with no command pending", m_tdata[31:0], '0);
			end else begin
				oldest_due = list_results_due.pop_front();
				results_checked++;
				if (m_tdata[1:0] !== oldest_due.status) begin
					report_mismatch("status", 32'(m_tdata[1:0]), 32'(oldest_due.status));
				end
				if (m_tdata[7:2] !== oldest_due.found_position) begin
					report_mismatch("found_position", 32'(m_tdata[7:2]),
					                32'(oldest_due.found_position));
				end
				if (m_tdata[39:8] !== oldest_due.read_value) begin
					report_mismatch("read_value", m_tdata[39:8], oldest_due.read_value);
				end
				if (m_tdata[46:40] !== oldest_due.entry_count) begin
					report_mismatch("entry_count", 32'(m_tdata[46:40]),
					                32'(oldest_due.entry_count));
				end
			end
		end
		if (stall_left != 0) begin
			m_tready   <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (!quiet && $urandom_range(0, 99) < 30) begin
			m_tready   <= 1'b0;
			stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(9, 39)
			                                          : $urandom_range(0, 2);
		end else begin
			m_tready <= 1'b1;
		end
	end

	task automatic send_cmd(input logic [2:0] cmd, input logic [5:0] pos,
	                        input logic [31:0] val);
		int gap;
		s_tvalid <= 1'b1;
		s_tdata  <= {7'd0, val, pos, cmd};
		do @(posedge clk); while (!s_tready);
		list_results_due.push_back(apply_list_cmd(cmd, pos, val));
		items_sent++;
		gap = sender_gap();
		// leave valid high when the next item follows at once
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (list_results_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [6:0] cap);
		cfg_wen   <= 1'b1;
		cfg_wdata <= cap;
		@(posedge clk);
		cfg_wen    <= 1'b0;
		shadow_cap  = cap;
		cap_writes++;
	endtask

	task automatic test_empty_list();
		send_cmd(oale_pkg::OP_READ, 6'd0, 32'h0);
		send_cmd(oale_pkg::OP_DEL_AT, 6'd0, 32'h0);
		send_cmd(oale_pkg::OP_INSERT, 6'd0, 32'h1234_5678);
		send_cmd(oale_pkg::OP_FIND, 6'd0, 32'h0);
		send_cmd(oale_pkg::OP_DEL_VAL, 6'd63, 32'hFFFF_FFFF);
		send_cmd(oale_pkg::OP_READ, 6'd63, 32'h0);
	endtask

	task automatic test_basic_ops();
		send_cmd(oale_pkg::OP_APPEND, 6'd0, 32'h0000_0000);
		send_cmd(oale_pkg::OP_APPEND, 6'd63, 32'hFFFF_FFFF);
		send_cmd(oale_pkg::OP_APPEND, 6'd21, 32'h5A5A_5A5A);
		send_cmd(oale_pkg::OP_INSERT, 6'd0, 32'h0000_0001);
		send_cmd(oale_pkg::OP_INSERT, 6'd2, 32'hAAAA_5555);
		// insert cannot target the end of the list
		send_cmd(oale_pkg::OP_INSERT, 6'd5, 32'hDEAD_BEEF);
		send_cmd(oale_pkg::OP_READ, 6'd0, 32'h0);
		send_cmd(oale_pkg::OP_READ, 6'd4, 32'hFFFF_FFFF);
		send_cmd(oale_pkg::OP_FIND, 6'd0, 32'hFFFF_FFFF);
		send_cmd(oale_pkg::OP_FIND, 6'd0, 32'h1234_5678);
		send_cmd(oale_pkg::OP_DEL_VAL, 6'd0, 32'h0000_0000);
		send_cmd(oale_pkg::OP_DEL_AT, 6'd0, 32'h0);
		send_cmd(oale_pkg::OP_DEL_AT, 6'd63, 32'h0);
		send_cmd(CMD_SPARE_6, 6'd0, 32'h0);
		send_cmd(CMD_SPARE_7, 6'd63, 32'hFFFF_FFFF);
	endtask

	task automatic test_capacity_limits();
		// capacity below the current count
		wait_idle();
		write_capacity(7'd2);
		send_cmd(oale_pkg::OP_APPEND, 6'd0, 32'h0000_0077);
		send_cmd(oale_pkg::OP_INSERT, 6'd0, 32'h0000_0088);
		send_cmd(oale_pkg::OP_READ, 6'd2, 32'h0);
		send_cmd(oale_pkg::OP_READ, 6'd1, 32'h0);
		send_cmd(oale_pkg::OP_DEL_AT, 6'd2, 32'h0);
		send_cmd(oale_pkg::OP_FIND, 6'd0, shadow_entries[2]);

		wait_idle();
		write_capacity(7'd0);
		send_cmd(oale_pkg::OP_APPEND, 6'd0, 32'h0000_0099);
		send_cmd(oale_pkg::OP_INSERT, 6'd0, 32'h0000_0099);
		send_cmd(oale_pkg::OP_DEL_VAL, 6'd0, shadow_entries[0]);

		// above the store depth: saturates, so fill the whole store
		wait_idle();
		write_capacity(7'd127);
		while (shadow_len < oale_pkg::DEPTH) begin
			send_cmd(oale_pkg::OP_APPEND, 6'($urandom), $urandom);
		end
		send_cmd(oale_pkg::OP_APPEND, 6'd0, 32'h0000_0001);
		send_cmd(oale_pkg::OP_INSERT, 6'd10, 32'h0000_0002);
		send_cmd(oale_pkg::OP_INSERT, 6'd63, 32'h0000_0003);
		send_cmd(oale_pkg::OP_READ, 6'd63, 32'h0);
		send_cmd(oale_pkg::OP_FIND, 6'd0, shadow_entries[63]);
		send_cmd(oale_pkg::OP_DEL_AT, 6'd63, 32'h0);
		send_cmd(oale_pkg::OP_DEL_AT, 6'd0, 32'h0);

		wait_idle();
		write_capacity(7'd65);
		send_cmd(oale_pkg::OP_APPEND, 6'd0, 32'hFFFF_FFFF);
		send_cmd(oale_pkg::OP_APPEND, 6'd0, 32'h0000_0000);
		send_cmd(oale_pkg::OP_APPEND, 6'd0, 32'h0000_0004);
	endtask

	function automatic logic [2:0] pick_command(input bit grow);
		int r;
		int w_app;
		int w_ins;
		int w_dval;
		int w_dat;
		int w_rd;
		w_app  = grow ? 34 : 12;
		w_ins  = grow ? 22 : 10;
		w_dval = grow ? 8 : 22;
		w_dat  = grow ? 8 : 22;
		w_rd   = 14;
		r = $urandom_range(0, 99);
		if (r < w_app) return oale_pkg::OP_APPEND;
		r -= w_app;
		if (r < w_ins) return oale_pkg::OP_INSERT;
		r -= w_ins;
		if (r < w_dval) return oale_pkg::OP_DEL_VAL;
		r -= w_dval;
		if (r < w_dat) return oale_pkg::OP_DEL_AT;
		r -= w_dat;
		if (r < w_rd) return oale_pkg::OP_READ;
		r -= w_rd;
		if (r < 96 - w_app - w_ins - w_dval - w_dat - w_rd) return oale_pkg::OP_FIND;
		return $urandom_range(0, 1) ? CMD_SPARE_6 : CMD_SPARE_7;
	endfunction

	task automatic test_random_traffic(input int n_items, input logic [6:0] cap);
		logic [31:0] pool [8];
		logic [2:0]  cmd;
		logic [5:0]  pos;
		logic [31:0] val;
		bit          grow;
		wait_idle();
		write_capacity(cap);
		// a small pool of values so finds and deletes by value hit, with duplicates
		foreach (pool[i]) pool[i] = $urandom;
		grow = 1'b1;
		for (int n = 0; n < n_items; n++) begin
			if (n % 40 == 0) begin
				quiet <= ($urandom_range(0, 3) == 0);
				grow   = $urandom_range(0, 1);
			end
			cmd = pick_command(grow);
			if ($urandom_range(0, 4) == 0) begin
				pos = 6'($urandom);
			end else begin
				pos = 6'($urandom_range(0, (shadow_len > 63) ? 63 : int'(shadow_len)));
			end
			val = ($urandom_range(0, 9) < 7) ? pool[$urandom_range(0, 7)] : $urandom;
			send_cmd(cmd, pos, val);
		end
		quiet <= 1'b0;
	endtask

	initial begin
		arst_n      = 1'b0;
		s_tvalid    = 1'b0;
		s_tdata     = '0;
		cfg_wen     = 1'b0;
		cfg_wdata   = '0;
		quiet       = 1'b0;
		shadow_len  = '0;
		shadow_cap  = 7'd64;
		mismatches  = 0;
		items_sent  = 0;
		results_checked = 0;
		cap_writes  = 0;
		foreach (shadow_entries[i]) shadow_entries[i] = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);

		test_empty_list();
		test_basic_ops();
		test_capacity_limits();
		test_random_traffic(120, 7'd64);
		test_random_traffic(70, 7'd8);
		test_random_traffic(50, 7'($urandom_range(1, 63)));
		test_random_traffic(30, 7'd1);
		test_random_traffic(30, 7'd127);

		wait_idle();
		repeat (WORST_WALK) @(posedge clk);
		$display("sent %0d commands under %0d capacity settings, checked %0d results",
		         items_sent, cap_writes, results_checked);
		$display("covered empty, full, shrunk and saturated lists, misses and spare codes");
		if (mismatches == 0) begin
			$display("ordered_array_list_engine test passed");
		end else begin
			$display("ordered_array_list_engine test failed");
		end
		$finish;
	end

endmodule
